// ----- sv/dmp_pkg.sv -----
// ============================================================================
// dmp_pkg
// Shared constants, codes and controller/datapath interface types for the
// disk union mask painter.
// ============================================================================
package dmp_pkg;

    // image and radius limits
    localparam int MAX_WIDTH  = 512;
    localparam int MAX_HEIGHT = 512;
    localparam int MAX_RADIUS = 127;

    // item field widths
    localparam int KIND_W  = 2;
    localparam int COL_W   = 9;
    localparam int ROW_W   = 9;
    localparam int SCALE_W = 16;
    localparam int DIM_W   = 10;

    // stream packing
    localparam int S_TDATA_W = ((COL_W + ROW_W + SCALE_W + 7) / 8) * 8;
    localparam int S_TUSER_W = KIND_W;
    localparam int M_TDATA_W = 8;

    // configuration port
    localparam int CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = CFG_INDEX_W'(1);

    // derived datapath widths
    localparam int COLA_W    = $clog2(MAX_WIDTH);
    localparam int ROWA_W    = $clog2(MAX_HEIGHT);
    localparam int RAD_W     = $clog2(MAX_RADIUS + 1);
    localparam int RAD_RAW_W = SCALE_W - 6;
    localparam int DY_W      = RAD_W + 1;
    localparam int SQ_W      = 2 * RAD_W;
    localparam int SUM_W     = SQ_W + 2;
    localparam int POS_W     = ((COL_W > RAD_W) ? COL_W : RAD_W) + 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_PAINT = 2'd0,
        KIND_READ  = 2'd1,
        KIND_CLEAR = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PINIT,
        ST_PADJ,
        ST_PWR,
        ST_RRD,
        ST_RSEL
    } state_t;

    typedef struct packed {
        logic load;       // capture item fields
        logic init;       // start disk walk at top row
        logic adjust;     // one half-width step
        logic mem_rd;     // read a mask row
        logic rd_item;    // read address is the item row
        logic mem_wr;     // write back painted row
        logic next_row;   // advance to next row
        logic clr_start;  // restart clear sweep
        logic clr_step;   // zero one row
        logic out_load;   // load result register
    } dmp_cmd_t;

    typedef struct packed {
        logic zero_radius;
        logic settled;
        logic row_ok;
        logic last_row;
        logic clr_done;
        logic out_free;
    } dmp_stat_t;

endpackage

// ----- sv/dmp_ctrl.sv -----
// ============================================================================
// dmp_ctrl
// Sequencer for clear sweeps, disk painting and mask reads.
// ============================================================================
module dmp_ctrl import dmp_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TUSER_W-1:0] s_tuser,
    input  dmp_stat_t            stat,
    output dmp_cmd_t             cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (stat.clr_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load = 1'b1;
                    unique case (kind_t'(s_tuser))
                        KIND_PAINT: state_next = ST_PINIT;
                        KIND_READ:  state_next = ST_RRD;
                        KIND_CLEAR: begin
                            cmd.clr_start = 1'b1;
                            state_next    = ST_CLEAR;
                        end
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_PINIT: begin
                if (stat.zero_radius) begin
                    state_next = ST_IDLE;
                end else begin
                    cmd.init   = 1'b1;
                    state_next = ST_PADJ;
                end
            end
            ST_PADJ: begin
                if (!stat.settled) begin
                    cmd.adjust = 1'b1;
                end else if (stat.row_ok) begin
                    cmd.mem_rd = 1'b1;
                    state_next = ST_PWR;
                end else if (stat.last_row) begin
                    state_next = ST_IDLE;
                end else begin
                    cmd.next_row = 1'b1;
                end
            end
            ST_PWR: begin
                cmd.mem_wr = 1'b1;
                if (stat.last_row) begin
                    state_next = ST_IDLE;
                end else begin
                    cmd.next_row = 1'b1;
                    state_next   = ST_PADJ;
                end
            end
            ST_RRD: begin
                cmd.mem_rd  = 1'b1;
                cmd.rd_item = 1'b1;
                state_next  = ST_RSEL;
            end
            ST_RSEL: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// ----- sv/dmp_datapath.sv -----
// ============================================================================
// dmp_datapath
// Mask row memory, disk row walker, span builder, config and result registers.
// ============================================================================
module dmp_datapath import dmp_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]       cfg_data,
    input  logic [S_TDATA_W-1:0]   s_tdata,
    input  dmp_cmd_t               cmd,
    output dmp_stat_t              stat,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata
);

    logic [DIM_W-1:0]  image_width_reg;
    logic [DIM_W-1:0]  image_height_reg;
    logic [COL_W-1:0]  cx_reg;
    logic [ROW_W-1:0]  cy_reg;
    logic [RAD_W-1:0]  r_reg;
    logic [SQ_W-1:0]   rr_reg;
    logic signed [DY_W-1:0] dy_reg;
    logic [SQ_W-1:0]   dy2_reg;
    logic [RAD_W-1:0]  hw_reg;
    logic [SQ_W-1:0]   hw2_reg;
    logic [ROWA_W-1:0] clr_cnt_reg;
    logic [MAX_WIDTH-1:0] rdata_reg;
    logic              m_tvalid_reg;
    logic              mask_bit_reg;

    logic [MAX_WIDTH-1:0] mask_mem [MAX_HEIGHT];

    logic [COL_W-1:0]     s_col;
    logic [ROW_W-1:0]     s_row;
    logic [SCALE_W-1:0]   s_scale;
    logic [RAD_RAW_W-1:0] rad_raw;
    logic [RAD_W-1:0]     rad_load;
    logic [SQ_W-1:0]      r_sq;
    logic [DIM_W-1:0]     w_eff;
    logic [DIM_W-1:0]     h_eff;
    logic [SQ_W:0]        hw2_up;
    logic [SUM_W-1:0]     up_sum;
    logic [SUM_W-1:0]     dn_sum;
    logic                 grow;
    logic                 shrink;
    logic signed [SUM_W-1:0] dy_ext;
    logic signed [SUM_W-1:0] dy2_step;
    logic signed [POS_W-1:0] y_pos;
    logic signed [POS_W-1:0] span_lo;
    logic signed [POS_W-1:0] span_hi;
    logic [MAX_WIDTH-1:0] span;
    logic [ROWA_W-1:0]    waddr;
    logic [ROWA_W-1:0]    raddr;
    logic [MAX_WIDTH-1:0] wdata;
    logic                 rd_bit;

    assign s_col   = s_tdata[COL_W-1:0];
    assign s_row   = s_tdata[COL_W +: ROW_W];
    assign s_scale = s_tdata[COL_W + ROW_W +: SCALE_W];

    // radius = scale >> 5, negative scales paint nothing, saturate at max
    assign rad_raw  = s_scale[SCALE_W-2:5];
    assign rad_load = s_scale[SCALE_W-1] ? '0 :
                      (rad_raw > RAD_RAW_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) :
                      rad_raw[RAD_W-1:0];

    assign r_sq = SQ_W'(r_reg) * SQ_W'(r_reg);

    assign w_eff = (image_width_reg > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH)
                                                         : image_width_reg;
    assign h_eff = (image_height_reg > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT)
                                                           : image_height_reg;

    // half-width tracking: largest hw with hw^2 + dy^2 <= r^2
    assign hw2_up = (SQ_W+1)'(hw2_reg) + (SQ_W+1)'({hw_reg, 1'b1});
    assign up_sum = SUM_W'(hw2_up) + SUM_W'(dy2_reg);
    assign dn_sum = SUM_W'(hw2_reg) + SUM_W'(dy2_reg);
    assign grow   = (up_sum <= SUM_W'(rr_reg));
    assign shrink = (dn_sum > SUM_W'(rr_reg));

    // (dy+1)^2 = dy^2 + 2dy + 1
    assign dy_ext   = SUM_W'(dy_reg);
    assign dy2_step = $signed(SUM_W'(dy2_reg)) + (dy_ext <<< 1) + SUM_W'(1);

    assign y_pos   = $signed(POS_W'(cy_reg)) + POS_W'(dy_reg);
    assign span_lo = $signed(POS_W'(cx_reg)) - $signed(POS_W'(hw_reg));
    assign span_hi = $signed(POS_W'(cx_reg)) + $signed(POS_W'(hw_reg));

    always_comb begin
        for (int i = 0; i < MAX_WIDTH; i++) begin
            span[i] = ($signed(POS_W'(i)) >= span_lo) &&
                      ($signed(POS_W'(i)) <= span_hi) &&
                      ($signed(POS_W'(i)) < $signed(POS_W'(w_eff)));
        end
    end

    assign stat.zero_radius = (r_reg == '0);
    assign stat.settled     = !grow && !shrink;
    assign stat.row_ok      = (y_pos >= 0) && (y_pos < $signed(POS_W'(h_eff)));
    assign stat.last_row    = (dy_reg == $signed({1'b0, r_reg}));
    assign stat.clr_done    = (clr_cnt_reg == ROWA_W'(MAX_HEIGHT - 1));
    assign stat.out_free    = !m_tvalid_reg || m_tready;

    assign waddr = cmd.clr_step ? clr_cnt_reg : y_pos[ROWA_W-1:0];
    assign raddr = cmd.rd_item ? cy_reg[ROWA_W-1:0] : y_pos[ROWA_W-1:0];
    assign wdata = cmd.clr_step ? '0 : (rdata_reg | span);

    assign rd_bit = rdata_reg[cx_reg[COLA_W-1:0]] &&
                    (DIM_W'(cx_reg) < w_eff) && (DIM_W'(cy_reg) < h_eff);

    // mask memory: one row written, one row read per cycle
    always_ff @(posedge aclk) begin
        if (cmd.mem_wr || cmd.clr_step) begin
            mask_mem[waddr] <= wdata;
        end
        if (cmd.mem_rd) begin
            rdata_reg <= mask_mem[raddr];
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= DIM_W'(512);
            image_height_reg <= DIM_W'(512);
            clr_cnt_reg      <= '0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            if (cfg_valid && cfg_index == REG_IMAGE_WIDTH) begin
                image_width_reg <= cfg_data;
            end
            if (cfg_valid && cfg_index == REG_IMAGE_HEIGHT) begin
                image_height_reg <= cfg_data;
            end
            if (cmd.clr_start) begin
                clr_cnt_reg <= '0;
            end else if (cmd.clr_step) begin
                clr_cnt_reg <= clr_cnt_reg + ROWA_W'(1);
            end
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cx_reg <= s_col;
            cy_reg <= s_row;
            r_reg  <= rad_load;
        end
        if (cmd.init) begin
            rr_reg  <= r_sq;
            dy2_reg <= r_sq;
            dy_reg  <= -$signed({1'b0, r_reg});
            hw_reg  <= '0;
            hw2_reg <= '0;
        end else if (cmd.adjust) begin
            if (grow) begin
                hw_reg  <= hw_reg + RAD_W'(1);
                hw2_reg <= hw2_up[SQ_W-1:0];
            end else if (shrink) begin
                hw_reg  <= hw_reg - RAD_W'(1);
                hw2_reg <= hw2_reg - SQ_W'({hw_reg, 1'b0}) + SQ_W'(1);
            end
        end else if (cmd.next_row) begin
            dy_reg  <= dy_reg + DY_W'(1);
            dy2_reg <= dy2_step[SQ_W-1:0];
        end
        if (cmd.out_load) begin
            mask_bit_reg <= rd_bit;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(M_TDATA_W-1)'(0), mask_bit_reg};

endmodule

// ----- sv/disk_union_mask_painter.sv -----
// ============================================================================
// disk_union_mask_painter
// Rebuilds a binary shape mask as the union of disks from a skeleton scale map.
// ============================================================================
// Each input transaction is a paint, a read or a clear. A paint takes its
// radius as scale >> 5 (scale is signed Q.4, so the radius is half the scale
// in pixels, truncated), saturated at MAX_RADIUS; negative scales and radius
// zero paint nothing. The mask lives in a memory of MAX_HEIGHT rows of
// MAX_WIDTH bits. A paint walks the disk one row at a time from top to bottom:
// a half-width tracker adds or drops one pixel per cycle, then an in-bounds
// row is read, then OR-ed with its span and written back in the next cycle.
// A paint of radius r covers 2r+1 rows and takes up to 2r half-width steps.
// A read fetches the item row, then waits until the output register is free
// (no result held, or m_tready high) before loading the bit; it returns the
// bit on m_tdata[0], and 0 outside the image size in use. A clear, and also
// reset, runs a sweep over all MAX_HEIGHT (512) rows, one row per cycle, while
// s_tready stays low. The block handles one transaction at a time; a finished
// read result sits in the output register while the next transaction is taken.
// Configuration writes are always accepted (cfg_ready is tied high) and should
// only be issued while the block is idle.
// ============================================================================
module disk_union_mask_painter import dmp_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,    // 0 image_width, 1 image_height
    input  logic [DIM_W-1:0]       cfg_data,
    // input transactions
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,      // col[8:0], row[17:9], scale[33:18]
    input  logic [S_TUSER_W-1:0]   s_tuser,      // kind[1:0]
    // read results
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata       // mask_bit[0]
);

    dmp_cmd_t  cmd;
    dmp_stat_t stat;

    assign cfg_ready = 1'b1;

    // sequencer: owns the handshake on the input side
    dmp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    // row memory, disk walker and result register
    dmp_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// ----- sv/dmp_checker.sv -----
// ============================================================================
// dmp_checker
// Port-level assertions for the disk union mask painter.
// ============================================================================
module dmp_checker import dmp_pkg::*; (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic [S_TUSER_W-1:0]   s_tuser,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [M_TDATA_W-1:0]   m_tdata
);

    // result held while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // reset starts the clearing sweep
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("input ready during clear after reset");

    // padding bits above mask_bit stay zero
    a_out_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[M_TDATA_W-1:1] == '0)
        else $error("nonzero padding on result");

    // a new result only comes out of a busy read, never straight from idle
    a_out_from_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result appeared without a read in progress");

    // known transactions leave s_tready low in the cycle after they are accepted
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready &&
        (s_tuser == KIND_PAINT || s_tuser == KIND_READ || s_tuser == KIND_CLEAR)
        |=> !s_tready)
        else $error("input ready right after accepting a transaction");

endmodule

bind disk_union_mask_painter dmp_checker u_dmp_checker (.*);
